// ----- rtl/ipv4rx_pkg.sv -----
package ipv4rx_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LOCAL_IP          = 2'd0,
        CFG_HANDLER_PROTOCOLS = 2'd1,
        CFG_HANDLER_COUNT     = 2'd2
    } cfg_index_t;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_ACCEPT     = 3'd0,
        VERDICT_SHORT      = 3'd1,
        VERDICT_BAD_HEADER = 3'd2,
        VERDICT_CHECKSUM   = 3'd3,
        VERDICT_NOT_OURS   = 3'd4,
        VERDICT_BAD_LENGTH = 3'd5,
        VERDICT_NO_HANDLER = 3'd6
    } verdict_t;

    localparam int DEFAULT_HANDLER_SLOTS = 8;

    localparam logic [3:0]  IHL_MASK       = 4'hF;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [15:0] MIN_HEADER     = 16'd20;
    localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

    // Header byte offsets
    localparam logic [5:0] POS_TOTAL_HI = 6'd2;
    localparam logic [5:0] POS_TOTAL_LO = 6'd3;
    localparam logic [5:0] POS_PROTOCOL = 6'd9;
    localparam logic [5:0] POS_CSUM_HI  = 6'd10;
    localparam logic [5:0] POS_CSUM_LO  = 6'd11;
    localparam logic [5:0] POS_SRC_LO   = 6'd12;
    localparam logic [5:0] POS_SRC_HI   = 6'd15;
    localparam logic [5:0] POS_DST_LO   = 6'd16;
    localparam logic [5:0] POS_DST_HI   = 6'd19;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 104;

    // One received byte
    typedef struct packed {
        logic [15:0] frame_length;
        logic        first_byte;
        logic [7:0]  data_byte;
    } item_t;

    // One verdict
    typedef struct packed {
        logic [15:0] payload_length;
        logic [5:0]  header_bytes;
        logic [31:0] destination_address;
        logic [31:0] source_address;
        logic [7:0]  protocol;
        logic [2:0]  handler_slot;
        verdict_t    verdict;
    } result_t;

    // IHL field scaled to bytes
    function automatic logic [5:0] ihl_bytes(input logic [3:0] ihl);
        ihl_bytes = {ihl, 2'b00};
    endfunction

endpackage

// ----- rtl/ipv4rx_cfg_regs.sv -----
module ipv4rx_cfg_regs
    import ipv4rx_pkg::*;
#(
    parameter int HANDLER_SLOTS = DEFAULT_HANDLER_SLOTS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [63:0]                cfg_data,
    output logic [31:0]                local_ip,
    output logic [HANDLER_SLOTS*8-1:0] handler_protocols,
    output logic [3:0]                 handler_count
);

    logic [31:0]                local_ip_reg;
    logic [HANDLER_SLOTS*8-1:0] handler_protocols_reg;
    logic [3:0]                 handler_count_reg;

    // The register file always takes a write transaction.
    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg          <= '0;
            handler_protocols_reg <= '0;
            handler_count_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOCAL_IP:
                    local_ip_reg <= cfg_data[31:0];
                CFG_HANDLER_PROTOCOLS:
                    handler_protocols_reg <= cfg_data[HANDLER_SLOTS*8-1:0];
                CFG_HANDLER_COUNT:
                    handler_count_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign local_ip          = local_ip_reg;
    assign handler_protocols = handler_protocols_reg;
    assign handler_count     = handler_count_reg;

endmodule

// ----- rtl/ipv4rx_in_slice.sv -----
module ipv4rx_in_slice
    import ipv4rx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  consume,
    output logic                  item_valid,
    output item_t                 item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The slot is free when empty or when its item is taken this cycle.
    assign s_tready = !valid_reg || consume;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte    <= s_tdata[7:0];
            item_reg.frame_length <= s_tdata[23:8];
            item_reg.first_byte   <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/ipv4rx_hdr_parse.sv -----
module ipv4rx_hdr_parse
    import ipv4rx_pkg::*;
#(
    parameter int HANDLER_SLOTS = DEFAULT_HANDLER_SLOTS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  item_t                      item,
    input  logic                       result_ready,
    input  logic [31:0]                local_ip,
    input  logic [HANDLER_SLOTS*8-1:0] handler_protocols,
    input  logic [3:0]                 handler_count,
    output logic                       consume,
    output logic                       result_valid,
    output result_t                    result
);

    logic [5:0]  pos_reg,      pos_next;
    logic [15:0] sum_reg,      sum_next;
    logic [7:0]  held_reg,     held_next;
    logic [15:0] frame_reg,    frame_next;
    logic [5:0]  hlen_reg,     hlen_next;
    logic [15:0] total_reg,    total_next;
    logic [7:0]  proto_reg,    proto_next;
    logic [15:0] stored_reg,   stored_next;
    logic [31:0] src_reg,      src_next;
    logic [31:0] dst_reg,      dst_next;
    logic        done_reg,     done_next;

    logic [3:0]  version;
    logic [3:0]  ihl;
    logic        active;
    logic [5:0]  pos;
    logic [16:0] sum_wide;
    logic [15:0] sum_fold;
    logic [7:0]  held_base;
    logic [15:0] sum_base;
    logic [HANDLER_SLOTS-1:0] slot_hit;
    logic        any_hit;
    logic [2:0]  first_slot;
    logic [15:0] payload;

    // An item is taken only when the result stage has room for a verdict.
    assign consume = item_valid && result_ready;

    assign version = item.data_byte[7:4];
    assign ihl     = item.data_byte[3:0] & IHL_MASK;

    // Protocol lookup, from registered fields only, first slot in use wins.
    always_comb
    begin
        for (int i = 0; i < HANDLER_SLOTS; i++)
        begin
            slot_hit[i] = (4'(i) < handler_count)
                       && (handler_protocols[i*8 +: 8] == proto_reg);
        end
        any_hit    = 1'b0;
        first_slot = '0;
        for (int i = HANDLER_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_hit[i])
            begin
                any_hit    = 1'b1;
                first_slot = 3'(i);
            end
        end
    end

    assign payload = total_reg - {10'd0, hlen_reg};

    // Per-byte field capture, checksum accumulation and verdict.
    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        held_next    = held_reg;
        frame_next   = frame_reg;
        hlen_next    = hlen_reg;
        total_next   = total_reg;
        proto_next   = proto_reg;
        stored_next  = stored_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        done_next    = done_reg;
        active       = 1'b0;
        pos          = pos_reg;
        held_base    = held_reg;
        sum_base     = sum_reg;
        sum_wide     = '0;
        sum_fold     = '0;
        result_valid = 1'b0;
        result       = '0;

        if (consume)
        begin
            if (item.first_byte)
            begin
                // A new packet clears everything captured so far.
                pos         = '0;
                held_base   = '0;
                sum_base    = '0;
                pos_next    = '0;
                sum_next    = '0;
                held_next   = '0;
                total_next  = '0;
                proto_next  = '0;
                stored_next = '0;
                src_next    = '0;
                dst_next    = '0;
                hlen_next   = '0;
                frame_next  = item.frame_length;
                done_next   = 1'b0;
                if (item.frame_length < MIN_HEADER)
                begin
                    result_valid   = 1'b1;
                    result.verdict = VERDICT_SHORT;
                    done_next      = 1'b1;
                end
                else if (version != IP_VERSION || ihl < MIN_IHL
                         || item.frame_length < {10'd0, ihl_bytes(ihl)})
                begin
                    result_valid   = 1'b1;
                    result.verdict = VERDICT_BAD_HEADER;
                    done_next      = 1'b1;
                end
                else
                begin
                    hlen_next = ihl_bytes(ihl);
                    active    = 1'b1;
                end
            end
            else if (!done_reg)
            begin
                active = 1'b1;
            end

            if (active)
            begin
                // Even bytes are held; odd bytes complete a 16-bit word.
                if (!pos[0])
                begin
                    held_next = item.data_byte;
                end
                else if (pos != POS_CSUM_LO)
                begin
                    sum_wide = {1'b0, sum_base} + {1'b0, held_base, item.data_byte};
                    sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
                    sum_next = sum_fold;
                end

                if (pos == POS_TOTAL_HI || pos == POS_TOTAL_LO)
                    total_next = {total_next[7:0], item.data_byte};
                else if (pos == POS_PROTOCOL)
                    proto_next = item.data_byte;
                else if (pos == POS_CSUM_HI || pos == POS_CSUM_LO)
                    stored_next = {stored_next[7:0], item.data_byte};
                else if (pos >= POS_SRC_LO && pos <= POS_SRC_HI)
                    src_next = {src_next[23:0], item.data_byte};
                else if (pos >= POS_DST_LO && pos <= POS_DST_HI)
                    dst_next = {dst_next[23:0], item.data_byte};

                if ({1'b0, pos} + 7'd1 >= {1'b0, hlen_next})
                begin
                    // Last header byte: run the checks in order.
                    result_valid               = 1'b1;
                    done_next                  = 1'b1;
                    result.protocol            = proto_reg;
                    result.source_address      = src_reg;
                    result.destination_address = dst_next;
                    result.header_bytes        = hlen_reg;
                    if (~sum_next != stored_reg)
                        result.verdict = VERDICT_CHECKSUM;
                    else if (dst_next != BROADCAST_ADDR && dst_next != local_ip)
                        result.verdict = VERDICT_NOT_OURS;
                    else if (total_reg < {10'd0, hlen_reg} || total_reg > frame_reg)
                        result.verdict = VERDICT_BAD_LENGTH;
                    else if (any_hit)
                    begin
                        result.verdict        = VERDICT_ACCEPT;
                        result.handler_slot   = first_slot;
                        result.payload_length = payload;
                    end
                    else
                    begin
                        result.verdict        = VERDICT_NO_HANDLER;
                        result.payload_length = payload;
                    end
                end
                else
                begin
                    pos_next = pos + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            held_reg   <= '0;
            frame_reg  <= '0;
            hlen_reg   <= '0;
            total_reg  <= '0;
            proto_reg  <= '0;
            stored_reg <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            done_reg   <= 1'b1;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            held_reg   <= held_next;
            frame_reg  <= frame_next;
            hlen_reg   <= hlen_next;
            total_reg  <= total_next;
            proto_reg  <= proto_next;
            stored_reg <= stored_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ----- rtl/ipv4rx_out_reg.sv -----
module ipv4rx_out_reg
    import ipv4rx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   result_valid,
    input  result_t                result,
    output logic                   result_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]             m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new verdict when empty or when the held one leaves now.
    assign result_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result_valid)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
            result_reg <= result;
    end

    // Pack the verdict fields onto the stream.
    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.verdict;
    assign m_tdata  = {7'd0,
                       result_reg.payload_length,
                       result_reg.header_bytes,
                       result_reg.destination_address,
                       result_reg.source_address,
                       result_reg.protocol,
                       result_reg.handler_slot};

endmodule

// ----- rtl/ipv4_receive_header_check.sv -----
// Channel  Direction  Handshake             Content
// s_       in         s_tvalid / s_tready   one packet byte, first-byte flag, frame length
// m_       out        m_tvalid / m_tready   one verdict per packet with header fields
// cfg_     in         cfg_valid / cfg_ready register index and write data
//
// One byte is taken every cycle while the result side is not stalled; the byte that decides
// a verdict passes the input register, and the verdict then the result register.
// The pace is set by the byte parser: one byte per cycle, held while the result register is full.
// Reset puts the block waiting for a packet; bytes without the first-byte flag are dropped.
// A stalled result holds the parser and then the input side, losing nothing.
module ipv4_receive_header_check
    import ipv4rx_pkg::*;
#(
    parameter int HANDLER_SLOTS = DEFAULT_HANDLER_SLOTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], frame_length[23:8]
    input  logic                   s_tuser,   // first_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // handler_slot[2:0], protocol[10:3],
                                              // source_address[42:11],
                                              // destination_address[74:43],
                                              // header_bytes[80:75],
                                              // payload_length[96:81], zero fill
    output logic [2:0]             m_tuser,   // verdict[2:0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data
);

    logic [31:0]                local_ip;
    logic [HANDLER_SLOTS*8-1:0] handler_protocols;
    logic [3:0]                 handler_count;
    logic                       consume;
    logic                       item_valid;
    item_t                      item;
    logic                       result_valid;
    logic                       result_ready;
    result_t                    result;

    // Configuration registers
    ipv4rx_cfg_regs #(
        .HANDLER_SLOTS(HANDLER_SLOTS)
    ) u_cfg_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .local_ip         (local_ip),
        .handler_protocols(handler_protocols),
        .handler_count    (handler_count)
    );

    // Input register
    ipv4rx_in_slice u_in_slice (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .consume   (consume),
        .item_valid(item_valid),
        .item      (item)
    );

    // Header parser and checks
    ipv4rx_hdr_parse #(
        .HANDLER_SLOTS(HANDLER_SLOTS)
    ) u_hdr_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item             (item),
        .result_ready     (result_ready),
        .local_ip         (local_ip),
        .handler_protocols(handler_protocols),
        .handler_count    (handler_count),
        .consume          (consume),
        .result_valid     (result_valid),
        .result           (result)
    );

    // Result register
    ipv4rx_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_valid(result_valid),
        .result      (result),
        .result_ready(result_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import ipv4rx_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_PERCENT   = 18;

    // Work items queued for the driver.
    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_CFG,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [7:0]  data;
        logic        first;
        logic [15:0] flen;
        cfg_index_t  idx;
        logic [63:0] value;
    } job_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_LOCAL_IP;
    logic [63:0]            cfg_data = '0;

    job_t    pending[$];
    result_t verdicts_due[$];
    int      verdicts_made = 0;
    int      verdicts_seen = 0;
    int      bad_verdicts = 0;
    int      bytes_taken = 0;
    int      stim_bytes = 0;
    int      settle = 0;
    int      idle_cycles = 0;
    logic    stim_done = 1'b0;
    logic    calm;

    // Generator's view of the configuration, used to aim addresses and protocols.
    logic [31:0] gen_ip = '0;
    logic [63:0] gen_protos = '0;

    // Predictor configuration and parser state.
    logic [31:0] own_ip = '0;
    logic [63:0] slot_protocols = '0;
    logic [3:0]  slots_used = '0;
    logic [5:0]  hdr_pos = '0;
    logic [15:0] csum_acc = '0;
    logic [7:0]  held_byte = '0;
    logic [15:0] frame_len_cap = '0;
    logic [5:0]  hdr_len = '0;
    logic [15:0] ip_length_cap = '0;
    logic [7:0]  proto_cap = '0;
    logic [15:0] csum_field_cap = '0;
    logic [31:0] src_cap = '0;
    logic [31:0] dst_cap = '0;
    logic        awaiting_first = 1'b1;

    ipv4_receive_header_check DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Both sides run without idling for a stretch in the middle of the run.
    assign calm = (bytes_taken >= 450) && (bytes_taken < 700);

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic void post_verdict(verdict_t v, logic [2:0] slot, logic [15:0] pay);
        result_t r;
        r.verdict             = v;
        r.handler_slot        = slot;
        r.protocol            = proto_cap;
        r.source_address      = src_cap;
        r.destination_address = dst_cap;
        r.header_bytes        = hdr_len;
        r.payload_length      = pay;
        verdicts_due.push_back(r);
        verdicts_made++;
        awaiting_first = 1'b1;
    endfunction

    function automatic void write_register(cfg_index_t idx, logic [63:0] value);
        case (idx)
            CFG_LOCAL_IP:          own_ip = value[31:0];
            CFG_HANDLER_PROTOCOLS: slot_protocols = value;
            CFG_HANDLER_COUNT:     slots_used = value[3:0];
            default:
            begin
            end
        endcase
    endfunction

    // Final checks once the last header byte has arrived.
    function automatic void judge_header();
        int  limit;
        int  i;
        bit  found;
        found = 1'b0;
        if (~csum_acc != csum_field_cap)
        begin
            post_verdict(VERDICT_CHECKSUM, 3'd0, 16'd0);
        end
        else if (dst_cap != BROADCAST_ADDR && dst_cap != own_ip)
        begin
            post_verdict(VERDICT_NOT_OURS, 3'd0, 16'd0);
        end
        else if (ip_length_cap < hdr_len || ip_length_cap > frame_len_cap)
        begin
            post_verdict(VERDICT_BAD_LENGTH, 3'd0, 16'd0);
        end
        else
        begin
            // Counts above the number of slots saturate.
            limit = (slots_used > DEFAULT_HANDLER_SLOTS) ? DEFAULT_HANDLER_SLOTS : slots_used;
            for (i = 0; i < limit && !found; i++)
            begin
                if (slot_protocols[8*i +: 8] == proto_cap)
                begin
                    post_verdict(VERDICT_ACCEPT, i[2:0], ip_length_cap - hdr_len);
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                post_verdict(VERDICT_NO_HANDLER, 3'd0, ip_length_cap - hdr_len);
            end
        end
    endfunction

    // Advances the header parser by one received byte.
    function automatic void parse_ip_byte(logic [7:0] b, logic first, logic [15:0] flen);
        logic [16:0] s;
        logic [5:0]  p;
        if (first)
        begin
            hdr_pos        = '0;
            csum_acc       = '0;
            held_byte      = '0;
            ip_length_cap  = '0;
            proto_cap      = '0;
            csum_field_cap = '0;
            src_cap        = '0;
            dst_cap        = '0;
            hdr_len        = '0;
            frame_len_cap  = flen;
            awaiting_first = 1'b0;
            if (flen < MIN_HEADER)
            begin
                post_verdict(VERDICT_SHORT, 3'd0, 16'd0);
                return;
            end
            if (b[7:4] != IP_VERSION || b[3:0] < MIN_IHL || flen < {10'd0, b[3:0], 2'b00})
            begin
                post_verdict(VERDICT_BAD_HEADER, 3'd0, 16'd0);
                return;
            end
            hdr_len = {b[3:0], 2'b00};
        end
        else if (awaiting_first)
        begin
            return;
        end

        p = hdr_pos;
        // Ones' complement sum over 16-bit words, skipping the stored checksum.
        if (!p[0])
        begin
            held_byte = b;
        end
        else if (p != POS_CSUM_LO)
        begin
            s = {1'b0, csum_acc} + {1'b0, held_byte, b};
            csum_acc = s[15:0] + {15'd0, s[16]};
        end

        if (p == POS_TOTAL_HI || p == POS_TOTAL_LO)
        begin
            ip_length_cap = {ip_length_cap[7:0], b};
        end
        else if (p == POS_PROTOCOL)
        begin
            proto_cap = b;
        end
        else if (p == POS_CSUM_HI || p == POS_CSUM_LO)
        begin
            csum_field_cap = {csum_field_cap[7:0], b};
        end
        else if (p >= POS_SRC_LO && p <= POS_SRC_HI)
        begin
            src_cap = {src_cap[23:0], b};
        end
        else if (p >= POS_DST_LO && p <= POS_DST_HI)
        begin
            dst_cap = {dst_cap[23:0], b};
        end

        if (p + 1 >= hdr_len)
        begin
            judge_header();
        end
        else
        begin
            hdr_pos = p + 6'd1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------

    function automatic void push_byte(logic [7:0] b, logic first, logic [15:0] flen, bit counts);
        job_t j;
        j.kind  = JOB_BYTE;
        j.data  = b;
        j.first = first;
        j.flen  = flen;
        pending.push_back(j);
        if (counts)
        begin
            stim_bytes++;
        end
    endfunction

    function automatic void push_cfg(cfg_index_t idx, logic [63:0] value);
        job_t j;
        j.kind  = JOB_CFG;
        j.idx   = idx;
        j.value = value;
        pending.push_back(j);
    endfunction

    // Waits for every verdict to arrive, then lets the pipeline settle,
    // and writes all three registers. Unused upper bits carry noise.
    function automatic void config_phase(logic [31:0] ip, logic [63:0] protos, logic [3:0] count);
        job_t j;
        j.kind = JOB_DRAIN;
        pending.push_back(j);
        push_cfg(CFG_LOCAL_IP, {32'($urandom), ip});
        push_cfg(CFG_HANDLER_PROTOCOLS, protos);
        push_cfg(CFG_HANDLER_COUNT, {28'($urandom), 32'($urandom), count});
        gen_ip     = ip;
        gen_protos = protos;
    endfunction

    // Protocol table drawn from a narrow range, so that slots repeat.
    function automatic logic [63:0] crowded_protocols();
        logic [63:0] t;
        int          i;
        for (i = 0; i < 8; i++)
        begin
            t[8*i +: 8] = 8'($urandom_range(0, 3));
        end
        return t;
    endfunction

    // Builds one header with a correct checksum unless told to spoil it, and queues its first
    // 'keep' bytes, followed, when the whole header is kept, by up to three payload bytes.
    function automatic void send_datagram(int unsigned ihl, int unsigned flen, int unsigned tot,
                                          logic [7:0] proto, logic [31:0] dst, bit corrupt,
                                          int unsigned keep);
        logic [7:0]  hdr [60];
        int unsigned sum;
        int unsigned n;
        logic [15:0] csum;
        for (n = 0; n < 60; n++)
        begin
            hdr[n] = 8'($urandom);
        end
        hdr[0] = {IP_VERSION, ihl[3:0]};
        hdr[2] = tot[15:8];
        hdr[3] = tot[7:0];
        hdr[9] = proto;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        hdr[10] = 8'd0;
        hdr[11] = 8'd0;
        sum = 0;
        for (n = 0; n < ihl * 4; n += 2)
        begin
            sum += {hdr[n], hdr[n+1]};
        end
        while (sum > 32'hFFFF)
        begin
            sum = (sum & 32'hFFFF) + (sum >> 16);
        end
        csum = ~sum[15:0];
        if (corrupt)
        begin
            csum ^= 16'($urandom_range(1, 65535));
        end
        {hdr[10], hdr[11]} = csum;
        for (n = 0; n < keep; n++)
        begin
            push_byte(hdr[n], n == 0, (n == 0) ? flen[15:0] : 16'($urandom), 1'b1);
        end
        if (keep == ihl * 4)
        begin
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0);
        end
    endfunction

    // Mostly well-formed packets; some carry a bad length, a bad checksum
    // or are cut short by the next packet.
    function automatic void random_datagram();
        int unsigned ihl;
        int unsigned hb;
        int unsigned flen;
        int unsigned tot;
        int unsigned r;
        logic [7:0]  proto;
        logic [31:0] dst;
        r    = $urandom_range(99);
        ihl  = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        hb   = ihl * 4;
        flen = ($urandom_range(3) == 0) ? $urandom_range(hb, 65535) : $urandom_range(hb, hb + 64);
        tot  = (r < 12) ? $urandom_range(0, 65535) : $urandom_range(hb, flen);
        case ($urandom_range(3))
            0:       proto = 8'($urandom);
            1:       proto = 8'($urandom_range(0, 3));
            default: proto = gen_protos[8*$urandom_range(7) +: 8];
        endcase
        case ($urandom_range(9))
            0, 1:    dst = $urandom;
            2, 3, 4: dst = BROADCAST_ADDR;
            default: dst = gen_ip;
        endcase
        send_datagram(ihl, flen, tot, proto, dst, (r >= 12 && r < 20),
                      (r >= 20 && r < 28) ? $urandom_range(1, hb - 1) : hb);
    endfunction

    // A random first byte with a frame length often too short, then junk.
    function automatic void send_noise();
        logic [15:0] flen;
        case ($urandom_range(2))
            0:       flen = 16'($urandom_range(0, 19));
            1:       flen = 16'($urandom_range(20, 64));
            default: flen = 16'($urandom);
        endcase
        push_byte(8'($urandom), 1'b1, flen, 1'b1);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0);
    endfunction

    function automatic void random_traffic(int n);
        int start;
        start = stim_bytes;
        while (stim_bytes - start < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                random_datagram();
            end
            else
            begin
                send_noise();
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: byte stream and register writes.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        logic byte_vld;
        logic cfg_vld;
        job_t job;
        if (rst_n)
        begin
            byte_vld = s_tvalid;
            cfg_vld  = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                parse_ip_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]);
                bytes_taken <= bytes_taken + 1;
                byte_vld = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_index, cfg_data);
                cfg_vld = 1'b0;
            end
            if (!byte_vld && !cfg_vld && pending.size() > 0)
            begin
                job = pending[0];
                case (job.kind)
                    JOB_BYTE:
                    begin
                        if (calm || $urandom_range(99) >= IDLE_PERCENT)
                        begin
                            s_tdata  <= {job.flen, job.data};
                            s_tuser  <= job.first;
                            byte_vld = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    JOB_CFG:
                    begin
                        cfg_index <= job.idx;
                        cfg_data  <= job.value;
                        cfg_vld   = 1'b1;
                        void'(pending.pop_front());
                    end
                    default:
                    begin
                        // Hold off until every verdict is in and the pipeline is quiet.
                        if (verdicts_made == verdicts_seen)
                        begin
                            settle = settle + 1;
                        end
                        else
                        begin
                            settle = 0;
                        end
                        if (settle >= SETTLE_CYCLES)
                        begin
                            settle = 0;
                            void'(pending.pop_front());
                        end
                    end
                endcase
            end
            s_tvalid  <= byte_vld;
            cfg_valid <= cfg_vld;
            stim_done <= !byte_vld && !cfg_vld && (pending.size() == 0);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each verdict transaction with the oldest prediction.
    // ---------------------------------------------------------------

    function automatic string fmt_verdict(result_t r);
        return $sformatf("v=%0d slot=%0d proto=%02h src=%08h dst=%08h hb=%0d pay=%0d",
                         r.verdict, r.handler_slot, r.protocol, r.source_address,
                         r.destination_address, r.header_bytes, r.payload_length);
    endfunction

    function automatic void note_mismatch(string what, result_t want, result_t got);
        bad_verdicts++;
        if (bad_verdicts <= REPORT_LIMIT)
        begin
            $display("%0s: expected %0s", what, fmt_verdict(want));
            $display("    actual %0s", fmt_verdict(got));
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            if (m_tvalid && m_tready)
            begin
                got.verdict             = verdict_t'(m_tuser);
                got.handler_slot        = m_tdata[2:0];
                got.protocol            = m_tdata[10:3];
                got.source_address      = m_tdata[42:11];
                got.destination_address = m_tdata[74:43];
                got.header_bytes        = m_tdata[80:75];
                got.payload_length      = m_tdata[96:81];
                if (verdicts_due.size() == 0)
                begin
                    note_mismatch("verdict with none pending", '0, got);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    verdicts_seen <= verdicts_seen + 1;
                    if (got.verdict !== want.verdict
                        || got.handler_slot !== want.handler_slot
                        || got.protocol !== want.protocol
                        || got.source_address !== want.source_address
                        || got.destination_address !== want.destination_address
                        || got.header_bytes !== want.header_bytes
                        || got.payload_length !== want.payload_length)
                    begin
                        note_mismatch("verdict mismatch", want, got);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------
    initial
    begin
        // Registers at their reset values: no local address, no handlers.
        config_phase(32'h0, 64'h0, 4'd0);

        // A stray byte while waiting for a packet is ignored.
        push_byte(8'h45, 1'b0, 16'h0000, 1'b1);
        // Frame shorter than a minimal header, at zero and just below the bound.
        push_byte(8'h45, 1'b1, 16'd0, 1'b1);
        push_byte(8'hFF, 1'b1, 16'd19, 1'b1);
        // Wrong version, header length below five words, header longer than the frame.
        push_byte(8'h65, 1'b1, 16'hFFFF, 1'b1);
        push_byte(8'h44, 1'b1, 16'd20, 1'b1);
        push_byte(8'h4F, 1'b1, 16'd59, 1'b1);
        // Packet abandoned by a new first byte part way through its header.
        push_byte(8'h45, 1'b1, 16'd40, 1'b1);
        push_byte(8'h00, 1'b0, 16'd0, 1'b1);
        // Broadcast packet at the largest frame length with no handlers.
        send_datagram(5, 65535, 20, 8'd17, BROADCAST_ADDR, 1'b0, 20);

        config_phase($urandom, crowded_protocols(), 4'd8);
        random_traffic(180);
        config_phase(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        random_traffic(180);
        config_phase($urandom, {$urandom, $urandom}, 4'($urandom_range(1, 7)));
        random_traffic(180);
        config_phase(32'h0, 64'h0, 4'd1);
        random_traffic(180);
        config_phase($urandom, crowded_protocols(), 4'($urandom_range(1, 8)));
        random_traffic(180);

        wait (stim_done);
        wait (verdicts_seen == verdicts_made);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (bad_verdicts == 0 && verdicts_due.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
